### src/deq_pkg.sv
// shared types and codes for the double-ended queue
`default_nettype none

package deq_pkg;

   // fixed field widths
   localparam int FUNC_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;

   // request operation codes
   typedef enum logic [FUNC_W-1:0] {
      FN_PUSH_FRONT = 3'd0,
      FN_PUSH_BACK  = 3'd1,
      FN_POP_FRONT  = 3'd2,
      FN_POP_BACK   = 3'd3,
      FN_READ       = 3'd4,
      FN_WRITE      = 3'd5,
      FN_SEARCH     = 3'd6
   } func_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_RANGE = 2'd2,
      STAT_FULL  = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_SEARCH
   } state_type;

endpackage

`default_nettype wire

### src/deq_ram.sv
// ring storage: one write port, one read port with registered read data
`default_nettype none

module deq_ram #(
   parameter int DEPTH  = 64,
   parameter int DATA_W = 32,
   localparam int AW    = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [AW-1:0]     rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### src/deque_with_index_and_search.sv
// Bounded double-ended queue of signed 32-bit values held as a ring in one
// synchronous memory, with a head slot and an entry count in registers. Each
// request transfer yields exactly one response transfer carrying status, data,
// found flag and the count after the request. Push, pop, write, the unused
// operation code, a read out of range and a search on an empty queue respond
// in the cycle after the request is taken; a valid read waits in S_READ for
// the registered memory read data; a search reads one stored entry per cycle
// from the front until it hits or has read every entry. The memory's single
// read port sets the search rate. One request is in work at a time; a new
// request is taken while the previous response still waits in the output
// register, as long as that response is being taken in the same cycle.
// Memory contents are not cleared at reset; only written entries are ever read.
`default_nettype none

module deque_with_index_and_search #(
   parameter int DEPTH          = 64,
   localparam int AW            = $clog2(DEPTH),
   localparam int CW            = $clog2(DEPTH + 1),
   localparam int REQ_BITS      = 35 + AW,
   localparam int REQ_TDATA_W   = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_BITS      = 35 + CW,
   localparam int RSP_TDATA_W   = ((RSP_BITS + 7) / 8) * 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request channel
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // func [2:0], value [34:3], position [35 +: AW], zero pad
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // response channel
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // status [1:0], data [33:2], found [34], count [35 +: CW], zero pad
   output logic      [RSP_TDATA_W-1:0] rsp_tdata
);

   import deq_pkg::*;

   localparam logic [AW:0]   DEPTH_W    = (AW + 1)'(DEPTH);
   localparam logic [AW-1:0] LAST_SLOT  = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   // ring slot of the entry at a given index from the front
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h,
                                             input logic [AW-1:0] i);
      logic [AW:0] sum;
      sum = {1'b0, h} + {1'b0, i};
      if (sum >= DEPTH_W) begin
         sum = sum - DEPTH_W;
      end
      return sum[AW-1:0];
   endfunction

   // request fields
   func_type                   req_func;
   logic signed [VALUE_W-1:0]  req_value;
   logic        [AW-1:0]       req_position;

   assign req_func     = func_type'(req_tdata[FUNC_W-1:0]);
   assign req_value    = req_tdata[FUNC_W +: VALUE_W];
   assign req_position = req_tdata[FUNC_W + VALUE_W +: AW];

   // state registers
   state_type                 state_ff, state_in;
   logic [AW-1:0]             head_ff, head_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [CW-1:0]             idx_ff, idx_in;
   logic signed [VALUE_W-1:0] key_ff, key_in;

   // response register
   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic signed [VALUE_W-1:0] rsp_data_ff, rsp_data_in;
   logic                      rsp_found_ff, rsp_found_in;
   logic [CW-1:0]             rsp_count_ff, rsp_count_in;

   // memory port signals
   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   logic [VALUE_W-1:0]        wr_data;
   logic [AW-1:0]             rd_addr;
   logic [VALUE_W-1:0]        rd_data;

   // condition flags
   logic req_fire;
   logic q_full;
   logic q_empty;
   logic pos_bad;
   logic key_hit;
   logic walk_done;
   logic [AW-1:0] head_dec;
   logic [AW-1:0] head_inc;

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign q_full     = (count_ff == FULL_COUNT);
   assign q_empty    = (count_ff == '0);
   assign pos_bad    = (CW'(req_position) >= count_ff);
   assign key_hit    = ($signed(rd_data) == key_ff);
   assign walk_done  = (idx_ff == count_ff);
   assign head_dec   = (head_ff == '0) ? LAST_SLOT : head_ff - AW'(1);
   assign head_inc   = (head_ff == LAST_SLOT) ? '0 : head_ff + AW'(1);

   deq_ram #(
      .DEPTH  (DEPTH),
      .DATA_W (VALUE_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_func == FN_READ && !pos_bad) begin
                  state_in = S_READ;
               end else if (req_func == FN_SEARCH && !q_empty) begin
                  state_in = S_SEARCH;
               end
            end
         end
         S_READ: begin
            state_in = S_IDLE;
         end
         S_SEARCH: begin
            if (key_hit || walk_done) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // datapath, memory control and response load
   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      key_in        = key_ff;
      wr_en         = 1'b0;
      wr_addr       = slot_of(head_ff, req_position);
      wr_data       = req_value;
      rd_addr       = slot_of(head_ff, idx_ff[AW-1:0]);
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               rsp_status_in = STAT_OK;
               rsp_data_in   = '0;
               rsp_found_in  = 1'b0;
               rsp_valid_in  = 1'b1;
               case (req_func)
                  FN_PUSH_FRONT: begin
                     if (q_full) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        head_in  = head_dec;
                        wr_en    = 1'b1;
                        wr_addr  = head_dec;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  FN_PUSH_BACK: begin
                     if (q_full) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = slot_of(head_ff, count_ff[AW-1:0]);
                        count_in = count_ff + CW'(1);
                     end
                  end
                  FN_POP_FRONT: begin
                     if (q_empty) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        head_in  = head_inc;
                        count_in = count_ff - CW'(1);
                     end
                  end
                  FN_POP_BACK: begin
                     if (q_empty) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        count_in = count_ff - CW'(1);
                     end
                  end
                  FN_READ: begin
                     if (pos_bad) begin
                        rsp_status_in = STAT_RANGE;
                     end else begin
                        // data comes back next cycle
                        rd_addr      = slot_of(head_ff, req_position);
                        rsp_valid_in = 1'b0;
                     end
                  end
                  FN_WRITE: begin
                     if (q_empty) begin
                        rsp_status_in = STAT_EMPTY;
                     end else if (pos_bad) begin
                        rsp_status_in = STAT_RANGE;
                     end else begin
                        wr_en = 1'b1;
                     end
                  end
                  FN_SEARCH: begin
                     key_in = req_value;
                     if (!q_empty) begin
                        // start the walk at the front entry
                        rd_addr      = head_ff;
                        idx_in       = CW'(1);
                        rsp_valid_in = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_count_in = count_in;
            end
         end
         S_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = STAT_OK;
            rsp_data_in   = $signed(rd_data);
            rsp_found_in  = 1'b0;
            rsp_count_in  = count_ff;
         end
         S_SEARCH: begin
            // rd_data holds the entry at index idx_ff - 1
            if (key_hit || walk_done) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_data_in   = '0;
               rsp_found_in  = key_hit;
               rsp_count_in  = count_ff;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      key_ff        <= key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // response channel
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_count_ff, rsp_found_ff, rsp_data_ff, rsp_status_ff});

endmodule

`default_nettype wire

### dv/tb_deque_with_index_and_search.sv
// self-checking testbench for the double-ended queue with index and search
module tb_deque_with_index_and_search;
   timeunit 1ns;
   timeprecision 1ps;

   import deq_pkg::*;

   localparam int DEPTH       = 64;
   localparam int REQ_W       = 48;
   localparam int RSP_W       = 48;
   localparam int ITEMS       = 1700;
   // longest search walks every stored entry
   localparam int SETTLE      = 2 * DEPTH + 16;
   localparam int HOLD_CYCLES = 400;
   localparam int HOLD_AFTER  = 300;
   localparam int REPORT_MAX  = 100;
   localparam longint LIMIT_NS = 10_000_000;

   // operation code that the block takes but does nothing with
   localparam logic [FUNC_W-1:0] FN_NONE = 3'd7;

   typedef struct {
      logic [FUNC_W-1:0]  func;
      logic signed [31:0] value;
      logic [5:0]         position;
   } deque_req_type;

   typedef struct {
      status_type         status;
      logic signed [31:0] data;
      logic               found;
      logic [6:0]         count;
   } deque_rsp_type;

   typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_type;
   typedef enum {RX_FREE, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   // stimulus and scoreboard storage
   deque_req_type request_backlog[$];
   deque_rsp_type due_replies[$];
   int            made           = 0;
   int            gen_count      = 0;
   int            requests_taken = 0;
   int            mismatches     = 0;

   // predicted queue contents
   logic [31:0] ring[DEPTH];
   logic [5:0]  front_slot = '0;
   int          stored     = 0;

   // sender and receiver pacing
   int          burst_left = 0;
   int          gap_left   = 0;
   int          hold_left  = 0;
   bit          hold_used  = 1'b0;
   rx_mode_type rx_mode    = RX_FREE;
   int          rx_left    = 0;
   int          rx_tick    = 0;

   always #5 clock = ~clock;

   deque_with_index_and_search #(.DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // apply one request to the predicted queue and return its response
   function automatic deque_rsp_type deque_apply(input deque_req_type rq);
      deque_rsp_type rs;
      logic [5:0]    slot;
      bit            hit;
      rs.status = STAT_OK;
      rs.data   = '0;
      rs.found  = 1'b0;
      hit       = 1'b0;
      case (rq.func)
         FN_PUSH_FRONT: begin
            if (stored >= DEPTH) begin
               rs.status = STAT_FULL;
            end else begin
               front_slot = front_slot - 6'd1;
               ring[front_slot] = rq.value;
               stored++;
            end
         end
         FN_PUSH_BACK: begin
            if (stored >= DEPTH) begin
               rs.status = STAT_FULL;
            end else begin
               slot = front_slot + 6'(stored);
               ring[slot] = rq.value;
               stored++;
            end
         end
         FN_POP_FRONT: begin
            if (stored == 0) begin
               rs.status = STAT_EMPTY;
            end else begin
               front_slot = front_slot + 6'd1;
               stored--;
            end
         end
         FN_POP_BACK: begin
            if (stored == 0) rs.status = STAT_EMPTY;
            else stored--;
         end
         FN_READ: begin
            if (int'(rq.position) >= stored) begin
               rs.status = STAT_RANGE;
            end else begin
               slot = front_slot + rq.position;
               rs.data = ring[slot];
            end
         end
         FN_WRITE: begin
            if (stored == 0) begin
               rs.status = STAT_EMPTY;
            end else if (int'(rq.position) >= stored) begin
               rs.status = STAT_RANGE;
            end else begin
               slot = front_slot + rq.position;
               ring[slot] = rq.value;
            end
         end
         FN_SEARCH: begin
            for (int i = 0; i < stored; i++) begin
               slot = front_slot + 6'(i);
               if (!hit && ring[slot] == rq.value) hit = 1'b1;
            end
            rs.found = hit;
         end
         default: begin
         end
      endcase
      rs.count = 7'(stored);
      return rs;
   endfunction

   task automatic log_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
      if (mismatches < REPORT_MAX)
         $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   // queue a request and track the fill level it leads to
   task automatic add_request(input logic [FUNC_W-1:0] fn, input logic [31:0] val,
                              input logic [5:0] pos);
      deque_req_type rq;
      rq.func     = fn;
      rq.value    = val;
      rq.position = pos;
      request_backlog.push_back(rq);
      made++;
      case (fn)
         FN_PUSH_FRONT, FN_PUSH_BACK: if (gen_count < DEPTH) gen_count++;
         FN_POP_FRONT, FN_POP_BACK:   if (gen_count > 0) gen_count--;
         default: begin
         end
      endcase
   endtask

   // small values repeat often so that searches hit
   function automatic logic [31:0] pick_value();
      logic [31:0] v;
      case ($urandom_range(9))
         0, 1, 2, 3: v = 32'($signed($urandom_range(15)) - 8);
         4: begin
            case ($urandom_range(3))
               0: v = 32'h8000_0000;
               1: v = 32'h7fff_ffff;
               2: v = '0;
               default: v = '1;
            endcase
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // mostly a valid index, sometimes anything
   function automatic logic [5:0] pick_position();
      if (gen_count > 0 && $urandom_range(7) != 0)
         return 6'($urandom_range(gen_count - 1));
      return 6'($urandom_range(DEPTH - 1));
   endfunction

   // stimulus, reset and end of run
   initial begin
      mix_type mix;
      int      run_len;
      int      roll;
      int      push_pct;
      int      pop_pct;

      // directed: empty queue errors, extremes, index limits, search hits and misses
      add_request(FN_POP_FRONT, '0, '0);
      add_request(FN_POP_BACK, '0, '0);
      add_request(FN_WRITE, 32'h1234_5678, '0);
      add_request(FN_READ, '0, '0);
      add_request(FN_SEARCH, '0, '0);
      add_request(FN_NONE, '1, 6'd63);
      add_request(FN_PUSH_BACK, 32'h7fff_ffff, '0);
      add_request(FN_PUSH_FRONT, 32'h8000_0000, 6'd63);
      add_request(FN_PUSH_BACK, '1, '0);
      add_request(FN_PUSH_FRONT, '0, '0);
      add_request(FN_READ, '0, 6'd0);
      add_request(FN_READ, '0, 6'd3);
      add_request(FN_READ, '0, 6'd4);
      add_request(FN_READ, '0, 6'd63);
      add_request(FN_WRITE, 32'h5a5a_5a5a, 6'd1);
      add_request(FN_WRITE, 32'ha5a5_a5a5, 6'd63);
      add_request(FN_SEARCH, '1, '0);
      add_request(FN_SEARCH, 32'h1234_5678, '0);
      add_request(FN_SEARCH, 32'h5a5a_5a5a, '0);
      add_request(FN_POP_BACK, '0, '0);
      add_request(FN_POP_FRONT, '0, '0);
      add_request(FN_READ, '0, 6'd1);
      add_request(FN_NONE, 32'h8000_0000, '0);

      // random runs, the first one weighted towards pushes to fill the queue
      mix = MIX_FILL;
      while (made < ITEMS) begin
         run_len = $urandom_range(60, 200);
         if (run_len > ITEMS - made) run_len = ITEMS - made;
         case (mix)
            MIX_FILL:  begin push_pct = 60; pop_pct = 10; end
            MIX_DRAIN: begin push_pct = 15; pop_pct = 45; end
            default:   begin push_pct = 30; pop_pct = 20; end
         endcase
         repeat (run_len) begin
            roll = $urandom_range(99);
            if (roll < push_pct) begin
               add_request($urandom_range(1) ? FN_PUSH_BACK : FN_PUSH_FRONT, pick_value(),
                           6'($urandom_range(DEPTH - 1)));
            end else if (roll < push_pct + pop_pct) begin
               add_request($urandom_range(1) ? FN_POP_BACK : FN_POP_FRONT, $urandom,
                           6'($urandom_range(DEPTH - 1)));
            end else begin
               case ($urandom_range(19))
                  0, 1, 2, 3, 4, 5, 6: add_request(FN_READ, $urandom, pick_position());
                  7, 8, 9, 10, 11:     add_request(FN_WRITE, pick_value(), pick_position());
                  12, 13, 14, 15, 16, 17, 18:
                     add_request(FN_SEARCH, pick_value(), 6'($urandom_range(DEPTH - 1)));
                  default: add_request(FN_NONE, $urandom, 6'($urandom_range(DEPTH - 1)));
               endcase
            end
         end
         mix = mix_type'($urandom_range(2));
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (request_backlog.size() != 0 || req_tvalid) @(posedge clock);
      while (due_replies.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #(LIMIT_NS);
      $display("%0t: timeout, %0d responses still due", $realtime, due_replies.size());
      $display("RESULT: ERROR");
      $finish;
   end

   // request driver: bursts with gaps, no gaps while the receiver holds off
   always @(posedge clock) begin
      deque_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left != 0 && hold_left == 0) begin
            gap_left   <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (request_backlog.size() != 0) begin
            nxt = request_backlog.pop_front();
            req_tdata  <= REQ_W'({nxt.position, nxt.value, nxt.func});
            req_tvalid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // long hold-off on the response side, once, so the input stalls
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_used <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_used && requests_taken >= HOLD_AFTER) begin
         hold_left <= HOLD_CYCLES;
         hold_used <= 1'b1;
      end
   end

   // response ready pattern, switching between modes
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_left    <= 0;
         rx_tick    <= 0;
      end else begin
         if (rx_left == 0) begin
            rx_mode <= rx_mode_type'($urandom_range(3));
            rx_left <= $urandom_range(20, 300);
         end else begin
            rx_left <= rx_left - 1;
         end
         rx_tick <= rx_tick + 1;
         if (hold_left != 0) begin
            rsp_tready <= 1'b0;
         end else begin
            case (rx_mode)
               RX_FREE:   rsp_tready <= 1'b1;
               RX_COIN:   rsp_tready <= 1'($urandom_range(1));
               RX_SPARSE: rsp_tready <= (rx_tick % 4 == 0);
               default:   rsp_tready <= ($urandom_range(9) != 0);
            endcase
         end
      end
   end

   // monitor: check each response transfer, predict each request transfer
   always @(posedge clock) begin
      deque_req_type seen;
      deque_rsp_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_replies.size() == 0) begin
               log_mismatch("response with none due", 64'(rsp_tdata), '0);
            end else begin
               want = due_replies.pop_front();
               if (rsp_tdata[1:0] !== want.status)
                  log_mismatch("status", 64'(rsp_tdata[1:0]), 64'(want.status));
               if (rsp_tdata[33:2] !== want.data)
                  log_mismatch("data", 64'(rsp_tdata[33:2]), 64'(want.data));
               if (rsp_tdata[34] !== want.found)
                  log_mismatch("found", 64'(rsp_tdata[34]), 64'(want.found));
               if (rsp_tdata[41:35] !== want.count)
                  log_mismatch("count", 64'(rsp_tdata[41:35]), 64'(want.count));
            end
         end
         if (req_tvalid && req_tready) begin
            seen.func     = req_tdata[2:0];
            seen.value    = req_tdata[34:3];
            seen.position = req_tdata[40:35];
            due_replies.push_back(deque_apply(seen));
            requests_taken++;
         end
      end
   end

endmodule
